### hw/rtl/lpas_pkg.sv
// ----------------------------------------------------------------------------
// lpas_pkg
// Shared types and constants for the line pixel address stepper.
// ----------------------------------------------------------------------------
package lpas_pkg;

    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    localparam int ROW_STRIDE_W = 9;
    localparam logic [ROW_STRIDE_W-1:0] ROW_STRIDE_RESET = 9'd240;
    localparam int COLOR_IN_W = 16;
    localparam int COLOR_W = 8;

    // Line core status, seen by the top level
    typedef struct packed
    {
        logic line_active;
        logic one_left;
    } core_status_t;

endpackage

### hw/rtl/lpas_input_stage.sv
// ----------------------------------------------------------------------------
// lpas_input_stage
// Input word register; holds an accepted word until the line core takes it.
// ----------------------------------------------------------------------------
module lpas_input_stage #(
    parameter int COORD_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [COORD_BITS-1:0]             start_x,
    input  logic [COORD_BITS-1:0]             start_y,
    input  logic [COORD_BITS-1:0]             end_x,
    input  logic [COORD_BITS-1:0]             end_y,
    input  logic [lpas_pkg::COLOR_IN_W-1:0]   color,
    input  logic                              advance,
    output logic                              item_valid,
    output logic                              item_kind,
    output logic [COORD_BITS-1:0]             item_x1,
    output logic [COORD_BITS-1:0]             item_y1,
    output logic [COORD_BITS-1:0]             item_x2,
    output logic [COORD_BITS-1:0]             item_y2,
    output logic [lpas_pkg::COLOR_W-1:0]      item_color
);
    import lpas_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic                  kind_reg;
    logic [COORD_BITS-1:0] x1_reg;
    logic [COORD_BITS-1:0] y1_reg;
    logic [COORD_BITS-1:0] x2_reg;
    logic [COORD_BITS-1:0] y2_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic                  take;

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind;
            x1_reg    <= start_x;
            y1_reg    <= start_y;
            x2_reg    <= end_x;
            y2_reg    <= end_y;
            color_reg <= color[COLOR_W-1:0];
        end
    end

    assign item_valid = valid_reg;
    assign item_kind  = kind_reg;
    assign item_x1    = x1_reg;
    assign item_y1    = y1_reg;
    assign item_x2    = x2_reg;
    assign item_y2    = y2_reg;
    assign item_color = color_reg;

endmodule

### hw/rtl/lpas_line_core.sv
// ----------------------------------------------------------------------------
// lpas_line_core
// Line state and one Bresenham step per word: loads a line on a start word,
// gives the current pixel and advances on a step word.
// ----------------------------------------------------------------------------
module lpas_line_core #(
    parameter int COORD_BITS = 8,
    parameter int ADDR_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [lpas_pkg::ROW_STRIDE_W-1:0]  row_stride,
    input  logic                               item_valid,
    input  logic                               item_kind,
    input  logic [COORD_BITS-1:0]              item_x1,
    input  logic [COORD_BITS-1:0]              item_y1,
    input  logic [COORD_BITS-1:0]              item_x2,
    input  logic [COORD_BITS-1:0]              item_y2,
    input  logic [lpas_pkg::COLOR_W-1:0]       item_color,
    input  logic                               out_free,
    output logic                               advance,
    output logic                               res_fire,
    output logic [ADDR_BITS-1:0]               res_address,
    output logic [lpas_pkg::COLOR_W-1:0]       res_color,
    output logic                               res_last,
    output lpas_pkg::core_status_t             status
);
    import lpas_pkg::*;

    localparam int ERR_W  = COORD_BITS + 2;
    localparam int CNT_W  = COORD_BITS + 1;
    localparam int PROD_W = COORD_BITS + ROW_STRIDE_W + 1;

    logic                     active_reg,   active_next;
    logic [ADDR_BITS-1:0]     addr_reg,     addr_next;
    logic signed [ERR_W-1:0]  err_reg,      err_next;
    logic [CNT_W-1:0]         left_reg,     left_next;
    logic [COORD_BITS-1:0]    adx_reg,      adx_next;
    logic [COORD_BITS-1:0]    ady_reg,      ady_next;
    logic                     xneg_reg,     xneg_next;
    logic                     yneg_reg,     yneg_next;
    logic                     xmaj_reg,     xmaj_next;
    logic [COLOR_W-1:0]       color_reg,    color_next;

    logic                     is_step;
    logic                     load;
    logic                     step;
    logic [PROD_W-1:0]        start_full;
    logic [ADDR_BITS-1:0]     stride_a;
    logic [ADDR_BITS-1:0]     one_a;
    logic [ADDR_BITS-1:0]     d_major;
    logic [ADDR_BITS-1:0]     d_minor;
    logic                     major_down;
    logic                     minor_down;
    logic [ADDR_BITS-1:0]     addr_major;
    logic [ADDR_BITS-1:0]     addr_both;
    logic signed [ERR_W-1:0]  err_add;
    logic signed [ERR_W-1:0]  err_sum;
    logic signed [ERR_W-1:0]  err_lim;
    logic signed [ERR_W-1:0]  err_sub;
    logic                     minor_step;
    logic                     s_yneg;
    logic                     s_xneg;
    logic [COORD_BITS-1:0]    s_ady;
    logic [COORD_BITS-1:0]    s_adx;
    logic                     s_xmaj;

    assign is_step  = (item_kind == KIND_STEP);
    // Step words without an active line are dropped with no result
    assign advance  = item_valid && (!is_step || !active_reg || out_free);
    assign load     = item_valid && !is_step;
    assign step     = item_valid && is_step && active_reg && out_free;
    assign res_fire = step;

    assign res_address = addr_reg;
    assign res_color   = color_reg;
    assign res_last    = (left_reg == CNT_W'(1));

    assign status.line_active = active_reg;
    assign status.one_left    = res_last;

    // Start word setup
    assign s_yneg = item_y2 < item_y1;
    assign s_xneg = item_x2 < item_x1;
    assign s_ady  = s_yneg ? (item_y1 - item_y2) : (item_y2 - item_y1);
    assign s_adx  = s_xneg ? (item_x1 - item_x2) : (item_x2 - item_x1);
    assign s_xmaj = s_adx > s_ady;
    assign start_full = PROD_W'(item_y1 * row_stride) + PROD_W'(item_x1);

    // Step datapath
    assign stride_a   = ADDR_BITS'(row_stride);
    assign one_a      = ADDR_BITS'(1);
    assign d_major    = xmaj_reg ? one_a : stride_a;
    assign d_minor    = xmaj_reg ? stride_a : one_a;
    assign major_down = xmaj_reg ? xneg_reg : yneg_reg;
    assign minor_down = xmaj_reg ? yneg_reg : xneg_reg;
    assign addr_major = major_down ? (addr_reg - d_major) : (addr_reg + d_major);
    assign addr_both  = minor_down ? (addr_major - d_minor) : (addr_major + d_minor);

    // x-major: err += dy, minor step when err > dx, err -= dx
    // y-major: err += dx, minor step when err > 0,  err -= dy
    assign err_add    = signed'(ERR_W'(xmaj_reg ? ady_reg : adx_reg));
    assign err_sum    = err_reg + err_add;
    assign err_lim    = xmaj_reg ? signed'(ERR_W'(adx_reg)) : '0;
    assign err_sub    = signed'(ERR_W'(xmaj_reg ? adx_reg : ady_reg));
    assign minor_step = err_sum > err_lim;

    always_comb
    begin
        active_next = active_reg;
        addr_next   = addr_reg;
        err_next    = err_reg;
        left_next   = left_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        xmaj_next   = xmaj_reg;
        color_next  = color_reg;
        if (load)
        begin
            active_next = 1'b1;
            addr_next   = ADDR_BITS'(start_full);
            err_next    = '0;
            left_next   = (s_xmaj ? CNT_W'(s_adx) : CNT_W'(s_ady)) + CNT_W'(1);
            adx_next    = s_adx;
            ady_next    = s_ady;
            xneg_next   = s_xneg;
            yneg_next   = s_yneg;
            xmaj_next   = s_xmaj;
            color_next  = item_color;
        end
        else if (step)
        begin
            addr_next   = minor_step ? addr_both : addr_major;
            err_next    = minor_step ? (err_sum - err_sub) : err_sum;
            if (left_reg != '0)
            begin
                left_next = left_reg - CNT_W'(1);
            end
            active_next = (left_reg > CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            addr_reg   <= '0;
            err_reg    <= '0;
            left_reg   <= '0;
            adx_reg    <= '0;
            ady_reg    <= '0;
            xneg_reg   <= 1'b0;
            yneg_reg   <= 1'b0;
            xmaj_reg   <= 1'b0;
            color_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            addr_reg   <= addr_next;
            err_reg    <= err_next;
            left_reg   <= left_next;
            adx_reg    <= adx_next;
            ady_reg    <= ady_next;
            xneg_reg   <= xneg_next;
            yneg_reg   <= yneg_next;
            xmaj_reg   <= xmaj_next;
            color_reg  <= color_next;
        end
    end

endmodule

### hw/rtl/lpas_output_stage.sv
// ----------------------------------------------------------------------------
// lpas_output_stage
// Result word register; holds a pixel until the downstream side takes it.
// ----------------------------------------------------------------------------
module lpas_output_stage #(
    parameter int ADDR_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_fire,
    input  logic [ADDR_BITS-1:0]           res_address,
    input  logic [lpas_pkg::COLOR_W-1:0]   res_color,
    input  logic                           res_last,
    output logic                           out_free,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ADDR_BITS-1:0]           pixel_address,
    output logic [lpas_pkg::COLOR_W-1:0]   pixel_color,
    output logic                           last
);
    import lpas_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic                 last_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            addr_reg  <= res_address;
            color_reg <= res_color;
            last_reg  <= res_last;
        end
    end

    assign out_valid     = valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = color_reg;
    assign last          = last_reg;

endmodule

### hw/rtl/line_pixel_address_stepper.sv
// ----------------------------------------------------------------------------
// line_pixel_address_stepper
// Bresenham line rasterizer giving linear frame-buffer pixel addresses.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  row_stride
//   in       in         in_valid / in_ready    kind, start_x/y, end_x/y, color
//   out      out        out_valid / out_ready  pixel_address, pixel_color, last
//
// Input word to result word: input register, then one step of the line
// core into the output register. One word per cycle sustained unless a result
// stalls; the step path is one address add pair and one error add and compare.
// Reset clears all line state; stride returns to 240. A stalled result
// holds the output register and, through it, a step word in the input register.
// ----------------------------------------------------------------------------
module line_pixel_address_stepper #(
    parameter int COORD_BITS = 8,
    parameter int ADDR_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lpas_pkg::ROW_STRIDE_W-1:0]  row_stride,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [COORD_BITS-1:0]              start_x,
    input  logic [COORD_BITS-1:0]              start_y,
    input  logic [COORD_BITS-1:0]              end_x,
    input  logic [COORD_BITS-1:0]              end_y,
    input  logic [lpas_pkg::COLOR_IN_W-1:0]    color,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ADDR_BITS-1:0]               pixel_address,
    output logic [lpas_pkg::COLOR_W-1:0]       pixel_color,
    output logic                               last
);
    import lpas_pkg::*;

    logic [ROW_STRIDE_W-1:0] stride_reg;
    logic                    item_valid;
    logic                    item_kind;
    logic [COORD_BITS-1:0]   item_x1;
    logic [COORD_BITS-1:0]   item_y1;
    logic [COORD_BITS-1:0]   item_x2;
    logic [COORD_BITS-1:0]   item_y2;
    logic [COLOR_W-1:0]      item_color;
    logic                    advance;
    logic                    out_free;
    logic                    res_fire;
    logic [ADDR_BITS-1:0]    res_address;
    logic [COLOR_W-1:0]      res_color;
    logic                    res_last;
    core_status_t            status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= ROW_STRIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            stride_reg <= row_stride;
        end
    end

    lpas_input_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .color      (color),
        .advance    (advance),
        .item_valid (item_valid),
        .item_kind  (item_kind),
        .item_x1    (item_x1),
        .item_y1    (item_y1),
        .item_x2    (item_x2),
        .item_y2    (item_y2),
        .item_color (item_color)
    );

    lpas_line_core #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_stride  (stride_reg),
        .item_valid  (item_valid),
        .item_kind   (item_kind),
        .item_x1     (item_x1),
        .item_y1     (item_y1),
        .item_x2     (item_x2),
        .item_y2     (item_y2),
        .item_color  (item_color),
        .out_free    (out_free),
        .advance     (advance),
        .res_fire    (res_fire),
        .res_address (res_address),
        .res_color   (res_color),
        .res_last    (res_last),
        .status      (status)
    );

    lpas_output_stage #(
        .ADDR_BITS (ADDR_BITS)
    ) u_output (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_fire      (res_fire),
        .res_address   (res_address),
        .res_color     (res_color),
        .res_last      (res_last),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last          (last)
    );

    // A result is only produced into a free output register
    a_fire_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> (!out_valid || out_ready))
        else $error("result produced while output register busy");

    // The final pixel of a line ends the line
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res_last) |=> !status.line_active)
        else $error("line still active after its last pixel");

    // A result always comes from an active line
    a_fire_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> (status.line_active && item_valid))
        else $error("result produced with no active line");

    // Input backpressure only when a word is waiting in the input register
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_valid && !advance))
        else $error("input stalled with nothing pending");

endmodule
